// ===== design/svpd_pkg.sv =====
// shared constants, tables and helpers of the space vector pwm duty block
`default_nettype none
package svpd_pkg;

	localparam int CORDIC_STEPS = 28;
	localparam int CW = 34;
	localparam int ANGLE_BITS_DEF = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] CFG_SUPPLY = 2'd0;
	localparam logic [1:0] CFG_PERIOD = 2'd1;

	localparam logic [15:0] SUPPLY_RST = 16'd12000;
	localparam logic [15:0] PERIOD_RST = 16'd2124;

	localparam logic [14:0] RATIO_CLAMP_Q15 = 15'd18907;
	localparam logic [15:0] ONE_Q15 = 16'h8000;
	localparam logic [31:0] SIXTH_TURN = 32'd715827883;
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	// (2^33 + 1) / 3, product shifted by 34 gives floor(x / 6)
	localparam logic [31:0] RECIP6 = 32'hAAAA_AAAB;

	localparam logic [2:0] SEC_1 = 3'd1;
	localparam logic [2:0] SEC_2 = 3'd2;
	localparam logic [2:0] SEC_3 = 3'd3;
	localparam logic [2:0] SEC_4 = 3'd4;
	localparam logic [2:0] SEC_5 = 3'd5;
	localparam logic [2:0] SEC_6 = 3'd6;

	// arctangent of 2^-i in 32-bit turns
	function automatic logic signed [CW-1:0] atan_turn(input int i);
		logic [31:0] v;
		begin
			case (i)
				0:  v = 32'h20000000;
				1:  v = 32'h12E4051E;
				2:  v = 32'h09FB385B;
				3:  v = 32'h051111D4;
				4:  v = 32'h028B0D43;
				5:  v = 32'h0145D7E1;
				6:  v = 32'h00A2F61E;
				7:  v = 32'h00517C55;
				8:  v = 32'h0028BE53;
				9:  v = 32'h00145F2F;
				10: v = 32'h000A2F98;
				11: v = 32'h000517CC;
				12: v = 32'h00028BE6;
				13: v = 32'h000145F3;
				14: v = 32'h0000A2FA;
				15: v = 32'h0000517D;
				16: v = 32'h000028BE;
				17: v = 32'h0000145F;
				18: v = 32'h00000A30;
				19: v = 32'h00000518;
				20: v = 32'h0000028C;
				21: v = 32'h00000146;
				22: v = 32'h000000A3;
				23: v = 32'h00000051;
				24: v = 32'h00000029;
				25: v = 32'h00000014;
				26: v = 32'h0000000A;
				27: v = 32'h00000005;
				default: v = 32'h0;
			endcase
			atan_turn = $signed({2'b00, v});
		end
	endfunction

endpackage
`default_nettype wire

// ===== design/svpd_if.sv =====
// valid/ready channel interfaces: request, result and configuration write
`default_nettype none
interface svpd_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] volt_q;
	logic signed [15:0] volt_d;
	logic [15:0] elec_angle;
	modport source(output valid, volt_q, volt_d, elec_angle, input ready);
	modport sink(input valid, volt_q, volt_d, elec_angle, output ready);
endinterface

interface svpd_out_if;
	logic valid;
	logic ready;
	logic [15:0] compare_a;
	logic [15:0] compare_b;
	logic [15:0] compare_c;
	logic [2:0] sector;
	modport source(output valid, compare_a, compare_b, compare_c, sector, input ready);
	modport sink(input valid, compare_a, compare_b, compare_c, sector, output ready);
endinterface

interface svpd_cfg_if;
	logic valid;
	logic ready;
	logic [svpd_pkg::CFG_IDX_W-1:0] index;
	logic [15:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/space_vector_pwm_duty.sv =====
// the pipeline has 64 stages, from the accepting edge up to the output register that holds the result
// throughput: one transaction per cycle; the whole pipeline moves as one and holds on a stall
// the latency is set by the 28-stage cordic lanes and the bit-per-stage root and divide chains
// reset clears all valid bits and loads supply 12000 mV and pwm period 2124
// configuration writes are taken every cycle
`default_nettype none
module space_vector_pwm_duty #(
	parameter int ANGLE_BITS = svpd_pkg::ANGLE_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	svpd_in_if.sink       sample,
	svpd_out_if.source    result,
	svpd_cfg_if.sink      cfg
);
	localparam int LAT = 64;
	localparam int CW = svpd_pkg::CW;

	// configuration registers
	logic [15:0] supply_q, period_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q <= svpd_pkg::SUPPLY_RST;
			period_q <= svpd_pkg::PERIOD_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				svpd_pkg::CFG_SUPPLY: supply_q <= cfg.data;
				svpd_pkg::CFG_PERIOD: period_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// global advance: every stage moves unless the output register is full and stalled
	logic adv;
	logic [LAT:1] vld_s;

	assign adv = !vld_s[LAT] || result.ready;
	assign sample.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-1:1], sample.valid};
		end
	end

	// stage 1: vectoring setup and sum of squares
	logic signed [CW-1:0] vx1, vy1, vz1;
	logic [31:0] sq1;
	logic signed [CW-1:0] dx, qy;
	logic signed [31:0] qq, dd;

	assign qq = sample.volt_q * sample.volt_q;
	assign dd = sample.volt_d * sample.volt_d;
	assign dx = CW'(sample.volt_d);
	assign qy = CW'(sample.volt_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			sq1 <= 32'(qq) + 32'(dd);
			if (sample.volt_d < 0) begin
				// fold the left half plane over by half a turn
				vx1 <= (-dx) <<< 14;
				vy1 <= (-qy) <<< 14;
				vz1 <= CW'(svpd_pkg::HALF_TURN);
			end else begin
				vx1 <= dx <<< 14;
				vy1 <= qy <<< 14;
				vz1 <= '0;
			end
		end
	end

	// delay lines for angle and zero-request flag, stages 1..29
	logic [15:0] ang_s [1:29];
	logic zero_s [1:29];

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s[1] <= sample.elec_angle;
			zero_s[1] <= (sample.volt_q == 0) && (sample.volt_d == 0);
			for (int k = 2; k <= 29; k++) begin
				ang_s[k] <= ang_s[k-1];
				zero_s[k] <= zero_s[k-1];
			end
		end
	end

	// atan2 lane, result at stage 29
	logic signed [CW-1:0] vz29;

	svpd_cordic #(.VECTOR(1'b1)) u_atan (
		.clk  (clk),
		.en   (adv),
		.x_i  (vx1),
		.y_i  (vy1),
		.z_i  (vz1),
		.res_o(vz29)
	);

	// magnitude: digit-by-digit square root, one result bit per stage 2..17
	logic [31:0] sv_s [1:17];
	logic [18:0] sr_s [1:17];
	logic [15:0] rt_s [1:17];

	assign sv_s[1] = sq1;
	assign sr_s[1] = '0;
	assign rt_s[1] = '0;

	for (genvar k = 1; k <= 16; k++) begin : g_sqrt
		logic [18:0] r, t;
		assign r = {sr_s[k][16:0], sv_s[k][31:30]};
		assign t = {1'b0, rt_s[k], 2'b01};
		always_ff @(posedge clk) begin
			if (adv) begin
				sv_s[k+1] <= {sv_s[k][29:0], 2'b00};
				if (r >= t) begin
					sr_s[k+1] <= r - t;
					rt_s[k+1] <= {rt_s[k][14:0], 1'b1};
				end else begin
					sr_s[k+1] <= r;
					rt_s[k+1] <= {rt_s[k][14:0], 1'b0};
				end
			end
		end
	end

	// ratio: restoring divide of mag * 2^15 by supply, stages 18..32
	logic [15:0] dr_s [18:32];
	logic [14:0] dq_s [18:32];
	logic big_s [18:32];

	for (genvar k = 18; k <= 32; k++) begin : g_div
		logic [15:0] rin;
		logic [14:0] qin;
		logic [16:0] r2;
		if (k == 18) begin : g_first
			assign rin = rt_s[17];
			assign qin = '0;
		end else begin : g_next
			assign rin = dr_s[k-1];
			assign qin = dq_s[k-1];
		end
		assign r2 = {rin, 1'b0};
		always_ff @(posedge clk) begin
			if (adv) begin
				if (r2 >= {1'b0, supply_q}) begin
					dr_s[k] <= 16'(r2 - {1'b0, supply_q});
					dq_s[k] <= {qin[13:0], 1'b1};
				end else begin
					dr_s[k] <= r2[15:0];
					dq_s[k] <= {qin[13:0], 1'b0};
				end
			end
		end
	end

	// a magnitude at or above supply (also supply of zero) saturates the ratio
	always_ff @(posedge clk) begin
		if (adv) begin
			big_s[18] <= rt_s[17] >= supply_q;
			for (int k = 19; k <= 32; k++) big_s[k] <= big_s[k-1];
		end
	end

	// stage 33: clamped ratio, then delayed to stage 61
	logic [14:0] u_s [33:61];

	always_ff @(posedge clk) begin
		if (adv) begin
			if (big_s[32] || dq_s[32] > svpd_pkg::RATIO_CLAMP_Q15) begin
				u_s[33] <= svpd_pkg::RATIO_CLAMP_Q15;
			end else begin
				u_s[33] <= dq_s[32];
			end
			for (int k = 34; k <= 61; k++) u_s[k] <= u_s[k-1];
		end
	end

	// stage 30: summed angle, sector and fraction inside the sector
	logic [31:0] sum30;
	logic [ANGLE_BITS-1:0] a30;
	logic [ANGLE_BITS+2:0] a6;
	logic [2:0] sidx;
	logic [31:0] fs30;
	logic [2:0] sec_s [30:64];

	assign sum30 = {ang_s[29], 16'h0000} + (zero_s[29] ? 32'h0 : vz29[31:0]);
	assign a30 = sum30[31 -: ANGLE_BITS];
	assign a6 = {3'b000, a30} * (ANGLE_BITS+3)'(6);
	assign sidx = a6[ANGLE_BITS+2:ANGLE_BITS];

	always_ff @(posedge clk) begin
		if (adv) begin
			sec_s[30] <= (sidx >= 3'd5) ? svpd_pkg::SEC_6 : sidx + 3'd1;
			fs30 <= 32'({a6[ANGLE_BITS-1:0], (32-ANGLE_BITS)'(0)});
			for (int k = 31; k <= 64; k++) sec_s[k] <= sec_s[k-1];
		end
	end

	// stage 31: divide by six through the reciprocal
	logic [63:0] p31;

	always_ff @(posedge clk) begin
		if (adv) p31 <= fs30 * svpd_pkg::RECIP6;
	end

	// stage 32: rotation setup for both sines
	logic signed [CW-1:0] rx32, ry32, za32, zb32;
	logic [29:0] phi;

	assign phi = p31[63:34];

	always_ff @(posedge clk) begin
		if (adv) begin
			rx32 <= CW'(svpd_pkg::CORDIC_GAIN_Q30);
			ry32 <= '0;
			za32 <= CW'(svpd_pkg::SIXTH_TURN) - CW'(phi);
			zb32 <= CW'(phi);
		end
	end

	// sine lanes, results at stage 60
	logic signed [CW-1:0] ya60, yb60;

	svpd_cordic #(.VECTOR(1'b0)) u_sin_a (
		.clk  (clk),
		.en   (adv),
		.x_i  (rx32),
		.y_i  (ry32),
		.z_i  (za32),
		.res_o(ya60)
	);

	svpd_cordic #(.VECTOR(1'b0)) u_sin_b (
		.clk  (clk),
		.en   (adv),
		.x_i  (rx32),
		.y_i  (ry32),
		.z_i  (zb32),
		.res_o(yb60)
	);

	// stage 61: q30 to q15 with clamp to 0..1
	logic signed [CW-1:0] sa, sb;
	logic [15:0] sa61, sb61;

	assign sa = ya60 >>> 15;
	assign sb = yb60 >>> 15;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (sa < 0) sa61 <= '0;
			else if (sa > CW'(svpd_pkg::ONE_Q15)) sa61 <= svpd_pkg::ONE_Q15;
			else sa61 <= sa[15:0];
			if (sb < 0) sb61 <= '0;
			else if (sb > CW'(svpd_pkg::ONE_Q15)) sb61 <= svpd_pkg::ONE_Q15;
			else sb61 <= sb[15:0];
		end
	end

	// stage 62: active vector times
	logic [30:0] m1, m2;
	logic [15:0] t1_62, t2_62;

	assign m1 = {16'h0, u_s[61]} * {15'h0, sa61};
	assign m2 = {16'h0, u_s[61]} * {15'h0, sb61};

	always_ff @(posedge clk) begin
		if (adv) begin
			t1_62 <= m1[30:15];
			t2_62 <= m2[30:15];
		end
	end

	// stage 63: zero time and sector table, duties in q16
	logic signed [18:0] t1e, t2e, t0e, dfull, d1, d2, da, db, dc;
	logic [16:0] da63, db63, dc63;

	assign t1e = 19'(t1_62);
	assign t2e = 19'(t2_62);
	assign t0e = 19'(svpd_pkg::ONE_Q15) - t1e - t2e;
	assign dfull = 19'(2) * (t1e + t2e) + t0e;
	assign d1 = 19'(2) * t1e + t0e;
	assign d2 = 19'(2) * t2e + t0e;

	always_comb begin
		case (sec_s[62])
			svpd_pkg::SEC_1: begin da = dfull; db = d2;    dc = t0e;   end
			svpd_pkg::SEC_2: begin da = d1;    db = dfull; dc = t0e;   end
			svpd_pkg::SEC_3: begin da = t0e;   db = dfull; dc = d2;    end
			svpd_pkg::SEC_4: begin da = t0e;   db = d1;    dc = dfull; end
			svpd_pkg::SEC_5: begin da = d2;    db = t0e;   dc = dfull; end
			default:         begin da = dfull; db = t0e;   dc = d1;    end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			da63 <= (da < 0) ? '0 : da[16:0];
			db63 <= (db < 0) ? '0 : db[16:0];
			dc63 <= (dc < 0) ? '0 : dc[16:0];
		end
	end

	// stage 64: compare values into the output register
	logic [32:0] ca, cb, cc;
	logic [15:0] cmpa_s64, cmpb_s64, cmpc_s64;

	assign ca = {16'h0, da63} * {17'h0, period_q};
	assign cb = {16'h0, db63} * {17'h0, period_q};
	assign cc = {16'h0, dc63} * {17'h0, period_q};

	always_ff @(posedge clk) begin
		if (adv) begin
			cmpa_s64 <= ca[31:16];
			cmpb_s64 <= cb[31:16];
			cmpc_s64 <= cc[31:16];
		end
	end

	assign result.valid = vld_s[LAT];
	assign result.compare_a = cmpa_s64;
	assign result.compare_b = cmpb_s64;
	assign result.compare_c = cmpc_s64;
	assign result.sector = sec_s[64];
endmodule
`default_nettype wire

// ===== design/svpd_cordic.sv =====
// pipelined cordic, one micro-rotation per stage, vectoring or rotation mode
`default_nettype none
module svpd_cordic #(
	parameter bit VECTOR = 1'b0
) (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic signed [svpd_pkg::CW-1:0] x_i,
	input  wire logic signed [svpd_pkg::CW-1:0] y_i,
	input  wire logic signed [svpd_pkg::CW-1:0] z_i,
	output logic signed [svpd_pkg::CW-1:0]      res_o
);
	localparam int N = svpd_pkg::CORDIC_STEPS;

	logic signed [svpd_pkg::CW-1:0] x_s [1:N];
	logic signed [svpd_pkg::CW-1:0] y_s [1:N];
	logic signed [svpd_pkg::CW-1:0] z_s [1:N];

	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [svpd_pkg::CW-1:0] xin, yin, zin, xs, ys;
		logic sig;
		if (i == 0) begin : g_first
			assign xin = x_i;
			assign yin = y_i;
			assign zin = z_i;
		end else begin : g_next
			assign xin = x_s[i];
			assign yin = y_s[i];
			assign zin = z_s[i];
		end
		assign xs = xin >>> i;
		assign ys = yin >>> i;
		// vectoring drives y toward zero, rotation drives z toward zero
		assign sig = VECTOR ? (yin <= 0) : (zin >= 0);
		always_ff @(posedge clk) begin
			if (en) begin
				if (sig) begin
					x_s[i+1] <= xin - ys;
					y_s[i+1] <= yin + xs;
					z_s[i+1] <= zin - svpd_pkg::atan_turn(i);
				end else begin
					x_s[i+1] <= xin + ys;
					y_s[i+1] <= yin - xs;
					z_s[i+1] <= zin + svpd_pkg::atan_turn(i);
				end
			end
		end
	end

	assign res_o = VECTOR ? z_s[N] : y_s[N];
endmodule
`default_nettype wire

// ===== bench/space_vector_pwm_duty_tb.sv =====
// testbench for the space vector pwm duty block: self-checking, random and directed
`default_nettype none
module space_vector_pwm_duty_tb;

	localparam int NSTEP = 28;
	localparam int ABITS = 16;
	localparam int LATENCY = 64;

	typedef struct packed {
		logic [15:0] cmp_a;
		logic [15:0] cmp_b;
		logic [15:0] cmp_c;
		logic [2:0] sec;
	} duty_t;

	logic clk;
	logic arst_n;

	svpd_in_if sample ();
	svpd_out_if result ();
	svpd_cfg_if cfg ();

	space_vector_pwm_duty #(.ANGLE_BITS(ABITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample),
		.result(result),
		.cfg(cfg)
	);

	// predictor copy of the two registers
	logic [15:0] supply_mv;
	logic [15:0] period_cnt;

	duty_t duty_queue[$];
	int n_fail;
	int n_items;
	int n_results;
	bit idle_on;

	// arctangent table, 32-bit turns
	function automatic longint atan_tab(input int i);
		longint t[NSTEP] = '{
			64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
			64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
			64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
			64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
			64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
			64'h00000014, 64'h0000000A, 64'h00000005};
		return t[i];
	endfunction

	// arithmetic shift right flooring toward minus infinity
	function automatic longint asr(input longint v, input int n);
		return v >>> n;
	endfunction

	function automatic longint unsigned root64(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// vector angle in 32-bit turns by cordic vectoring
	function automatic logic [31:0] vec_angle(input longint y, input longint x);
		logic [31:0] z;
		longint xs, ys;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		x *= 16384;
		y *= 16384;
		for (int i = 0; i < NSTEP; i++) begin
			xs = asr(x, i);
			ys = asr(y, i);
			if (y > 0) begin
				x += ys; y -= xs; z += 32'(atan_tab(i));
			end else begin
				x -= ys; y += xs; z -= 32'(atan_tab(i));
			end
		end
		return z;
	endfunction

	// sine in q15, angle within one sector
	function automatic longint sine_q15(input longint phi);
		longint x, y, z, xs, ys, s;
		x = 652032874;
		y = 0;
		z = phi;
		for (int i = 0; i < NSTEP; i++) begin
			xs = asr(x, i);
			ys = asr(y, i);
			if (z >= 0) begin
				x -= ys; y += xs; z -= atan_tab(i);
			end else begin
				x += ys; y -= xs; z += atan_tab(i);
			end
		end
		s = asr(y, 15);
		if (s < 0) s = 0;
		if (s > 32768) s = 32768;
		return s;
	endfunction

	function automatic logic [15:0] scale_duty(input longint d);
		longint unsigned p;
		if (d < 0) d = 0;
		p = (longint'(d) * longint'(period_cnt)) >> 16;
		return p[15:0];
	endfunction

	function automatic duty_t predict_duty(input logic signed [15:0] vq,
			input logic signed [15:0] vd, input logic [15:0] ang);
		longint q, d, t1, t2, t0, da, db, dc;
		longint unsigned mag, u, a, a6, f, phi;
		logic [31:0] sum;
		int s;
		duty_t r;
		q = vq;
		d = vd;
		mag = root64(q * q + d * d);
		if (supply_mv == 0) u = 18907;
		else u = (mag << 15) / supply_mv;
		if (u > 18907) u = 18907;
		sum = {ang, 16'h0} + vec_angle(q, d);
		a = sum >> (32 - ABITS);
		a6 = a * 6;
		s = int'(a6 >> ABITS) + 1;
		if (s > 6) s = 6;
		f = a6 & ((64'd1 << ABITS) - 1);
		phi = (f << (32 - ABITS)) / 6;
		t1 = (u * sine_q15(longint'(svpd_pkg::SIXTH_TURN) - longint'(phi))) >> 15;
		t2 = (u * sine_q15(phi)) >> 15;
		t0 = 32768 - t1 - t2;
		case (s)
			1: begin da = 2*(t1+t2)+t0; db = 2*t2+t0; dc = t0; end
			2: begin da = 2*t1+t0; db = 2*(t1+t2)+t0; dc = t0; end
			3: begin da = t0; db = 2*(t1+t2)+t0; dc = 2*t2+t0; end
			4: begin da = t0; db = 2*t1+t0; dc = 2*(t1+t2)+t0; end
			5: begin da = 2*t2+t0; db = t0; dc = 2*(t1+t2)+t0; end
			default: begin da = 2*(t1+t2)+t0; db = t0; dc = 2*t1+t0; end
		endcase
		r.cmp_a = scale_duty(da);
		r.cmp_b = scale_duty(db);
		r.cmp_c = scale_duty(dc);
		r.sec = 3'(s);
		return r;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// random idle decision, about 30 in 100 when enabled
	function automatic bit take_gap();
		return idle_on && ($urandom_range(99) < 30);
	endfunction

	// send one request transaction and record its expectation
	task automatic send_request(input logic signed [15:0] vq,
			input logic signed [15:0] vd, input logic [15:0] ang);
		while (take_gap()) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.volt_q <= vq;
		sample.volt_d <= vd;
		sample.elec_angle <= ang;
		duty_queue.push_back(predict_duty(vq, vd, ang));
		@(posedge clk);
		while (!sample.ready) @(posedge clk);
		n_items++;
	endtask

	// wait for every expectation, then let the pipe drain
	task automatic drain_results();
		sample.valid <= 1'b0;
		while (duty_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [svpd_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		if (idx == svpd_pkg::CFG_SUPPLY) supply_mv = val;
		else if (idx == svpd_pkg::CFG_PERIOD) period_cnt = val;
		@(posedge clk);
	endtask

	task automatic set_regs(input logic [15:0] sup, input logic [15:0] per);
		drain_results();
		write_reg(svpd_pkg::CFG_SUPPLY, sup);
		write_reg(svpd_pkg::CFG_PERIOD, per);
	endtask

	// result side: random stall, compare against oldest expectation
	always @(posedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				if (duty_queue.size() == 0) begin
					$display("%0t: unexpected result a=%0d b=%0d c=%0d sector=%0d", $time,
						result.compare_a, result.compare_b, result.compare_c, result.sector);
					n_fail++;
				end else begin
					automatic duty_t e = duty_queue.pop_front();
					n_results++;
					if (result.compare_a !== e.cmp_a) begin
						$display("%0t: compare_a expected %0d actual %0d", $time, e.cmp_a,
							result.compare_a);
						n_fail++;
					end
					if (result.compare_b !== e.cmp_b) begin
						$display("%0t: compare_b expected %0d actual %0d", $time, e.cmp_b,
							result.compare_b);
						n_fail++;
					end
					if (result.compare_c !== e.cmp_c) begin
						$display("%0t: compare_c expected %0d actual %0d", $time, e.cmp_c,
							result.compare_c);
						n_fail++;
					end
					if (result.sector !== e.sec) begin
						$display("%0t: sector expected %0d actual %0d", $time, e.sec,
							result.sector);
						n_fail++;
					end
				end
			end
			result.ready <= !take_gap();
		end
	end

	// zero request, extremes of each field, every sector
	task automatic test_directed();
		send_request(16'sd0, 16'sd0, 16'd0);
		send_request(16'sd0, 16'sd0, 16'hFFFF);
		send_request(16'sh7FFF, 16'sh7FFF, 16'd0);
		send_request(-16'sh8000, -16'sh8000, 16'hFFFF);
		send_request(16'sh7FFF, -16'sh8000, 16'h8000);
		send_request(-16'sh8000, 16'sd0, 16'h4000);
		send_request(16'sd0, 16'sh7FFF, 16'h1234);
		send_request(16'sd1, 16'sd0, 16'd0);
		send_request(16'sd0, -16'sd1, 16'd1);
		// one request in the middle of each sector and at each boundary
		for (int k = 0; k < 6; k++) begin
			send_request(16'sd0, 16'sd3000, 16'(k * 10923 + 5461));
			send_request(16'sd0, 16'sd6000, 16'(k * 10923));
		end
	endtask

	// random requests, mostly moderate, with full-range noise
	task automatic test_random(input int count);
		logic signed [15:0] vq, vd;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(3) == 0) begin
				vq = 16'($urandom);
				vd = 16'($urandom);
			end else begin
				vq = $signed(16'($urandom_range(16000))) - 16'sd8000;
				vd = $signed(16'($urandom_range(16000))) - 16'sd8000;
			end
			send_request(vq, vd, 16'($urandom));
		end
	endtask

	// registers at their extremes and in between, including zero values
	task automatic test_config_sweep();
		set_regs(16'd1000, 16'd65535);
		test_random(60);
		set_regs(16'd65535, 16'd1);
		test_random(60);
		set_regs(16'd0, 16'd0);
		test_random(30);
		set_regs(16'd0, 16'd4000);
		test_random(40);
		set_regs(16'($urandom_range(1000, 65535)), 16'($urandom_range(1, 65535)));
		test_random(60);
	endtask

	initial begin
		n_fail = 0;
		n_items = 0;
		n_results = 0;
		idle_on = 1'b1;
		supply_mv = svpd_pkg::SUPPLY_RST;
		period_cnt = svpd_pkg::PERIOD_RST;
		arst_n = 1'b0;
		sample.valid = 1'b0;
		sample.volt_q = '0;
		sample.volt_d = '0;
		sample.elec_angle = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset values first
		test_directed();
		test_random(200);
		// sender holds off until the pipe is empty
		drain_results();
		test_random(100);
		// no idling on either side for a long stretch
		idle_on = 1'b0;
		test_random(200);
		idle_on = 1'b1;
		test_config_sweep();
		test_random(100);
		drain_results();
		$display("covered %0d requests and %0d results over reset, extreme and random settings",
			n_items, n_results);
		if (n_fail == 0 && duty_queue.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/svpd_pkg.sv
design/svpd_if.sv
design/svpd_cordic.sv
design/space_vector_pwm_duty.sv
bench/space_vector_pwm_duty_tb.sv
